[sv/hld_pkg.sv]
// ----------------------------------------------------------------------------
// hld_pkg: shared definitions of the hex line drawing block
// Widths, defaults, the step plan passed from front to back, and the
// rounding helpers used by the back end stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package hld_pkg;

	localparam int HLD_COORD_BITS = 16;
	localparam int HLD_MAX_STEPS  = 63;
	localparam int QUEUE_DEPTH    = 2;

	// Step counter width; a line never has more than 63 steps.
	localparam int STEP_BITS = 6;
	// A per-line delta is at most the step count in magnitude.
	localparam int DLT_BITS  = STEP_BITS + 1;
	// Scaled rounding error (twice the error) and the tie-break key.
	localparam int ERR_BITS  = STEP_BITS + 2;
	localparam int KEY_BITS  = STEP_BITS + 4;
	// Remainder update range: rem plus or minus twice a delta.
	localparam int ACC_BITS  = STEP_BITS + 4;

	typedef struct packed {
		logic signed [DLT_BITS-1:0] dq;
		logic signed [DLT_BITS-1:0] dr;
		logic signed [DLT_BITS-1:0] ds;
		logic        [STEP_BITS-1:0] n;
		logic                        far;
	} step_plan_t;

	typedef struct packed {
		logic signed [DLT_BITS-1:0] v;
		logic        [DLT_BITS-1:0] rem;
	} rnd_state_t;

	// Key of a component rounded with an upward nudge; e is twice the error.
	function automatic logic [KEY_BITS-1:0] key_up(input logic signed [ERR_BITS-1:0] e);
		logic signed [KEY_BITS-1:0] x4;
		x4 = KEY_BITS'(e) <<< 2;
		return (e > 0) ? $unsigned(x4 - KEY_BITS'(1)) : $unsigned(KEY_BITS'(1) - x4);
	endfunction

	// Key of the component rounded with the doubled downward nudge.
	function automatic logic [KEY_BITS-1:0] key_dn(input logic signed [ERR_BITS-1:0] f);
		logic signed [KEY_BITS-1:0] x4;
		x4 = KEY_BITS'(f) <<< 2;
		return (f < 0) ? $unsigned(-x4 - KEY_BITS'(2)) : $unsigned(x4 + KEY_BITS'(2));
	endfunction

	// Moves a running quotient and remainder over 2*den by one step of 2*d.
	// The step never exceeds the divisor, so one correction is enough.
	function automatic rnd_state_t rnd_advance(input rnd_state_t st,
	                                           input logic signed [DLT_BITS-1:0] d,
	                                           input logic [DLT_BITS-1:0] den2);
		logic signed [ACC_BITS-1:0] acc;
		logic signed [ACC_BITS-1:0] lim;
		rnd_state_t nx;
		acc = $signed({{(ACC_BITS-DLT_BITS){1'b0}}, st.rem}) + (ACC_BITS'(d) <<< 1);
		lim = $signed({{(ACC_BITS-DLT_BITS){1'b0}}, den2});
		nx = st;
		if (acc < 0) begin
			nx.rem = DLT_BITS'(acc + lim);
			nx.v   = st.v - DLT_BITS'(1);
		end else if (acc >= lim) begin
			nx.rem = DLT_BITS'(acc - lim);
			nx.v   = st.v + DLT_BITS'(1);
		end else begin
			nx.rem = DLT_BITS'(acc);
		end
		return nx;
	endfunction

endpackage

`default_nettype wire

[sv/hld_line_if.sv]
// ----------------------------------------------------------------------------
// hld_line_if: line request channel
// One beat carries the start and end cells of a line in cube coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface hld_line_if #(
	parameter int CW = hld_pkg::HLD_COORD_BITS
);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] start_q;
	logic signed [CW-1:0] start_r;
	logic signed [CW-1:0] end_q;
	logic signed [CW-1:0] end_r;

	modport source (output valid, output start_q, output start_r,
	                output end_q, output end_r, input ready);
	modport sink   (input valid, input start_q, input start_r,
	                input end_q, input end_r, output ready);
endinterface

`default_nettype wire

[sv/hld_cell_if.sv]
// ----------------------------------------------------------------------------
// hld_cell_if: line cell channel
// One beat carries one cell of a drawn line and its end and range flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface hld_cell_if #(
	parameter int CW = hld_pkg::HLD_COORD_BITS
);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] cell_q;
	logic signed [CW-1:0] cell_r;
	logic signed [CW:0]   cell_s;
	logic                 last_cell;
	logic                 too_far;

	modport source (output valid, output cell_q, output cell_r, output cell_s,
	                output last_cell, output too_far, input ready);
	modport sink   (input valid, input cell_q, input cell_r, input cell_s,
	                input last_cell, input too_far, output ready);
endinterface

`default_nettype wire

[sv/hld_front.sv]
// ----------------------------------------------------------------------------
// hld_front: request classifier
// Computes the deltas and the hex distance of a request and decides whether
// the line can be drawn or is reported as out of range.
// ----------------------------------------------------------------------------
`default_nettype none

module hld_front #(
	parameter int CW        = hld_pkg::HLD_COORD_BITS,
	parameter int MAX_STEPS = hld_pkg::HLD_MAX_STEPS
) (
	hld_line_if.sink             line,
	output logic                 push_valid,
	input  logic                 push_ready,
	output logic signed [CW-1:0] push_org_q,
	output logic signed [CW-1:0] push_org_r,
	output hld_pkg::step_plan_t  push_plan
);
	import hld_pkg::*;

	localparam int NW = CW + 2;

	logic signed [CW:0]   dq;
	logic signed [CW:0]   dr;
	logic signed [CW+1:0] ds;
	logic        [CW:0]   abs_q;
	logic        [CW:0]   abs_r;
	logic        [CW+1:0] abs_s;
	logic        [CW+2:0] sum;
	logic        [NW-1:0] hex_dist;
	logic                 far;

	always_comb begin
		dq       = (CW+1)'(line.end_q) - (CW+1)'(line.start_q);
		dr       = (CW+1)'(line.end_r) - (CW+1)'(line.start_r);
		ds       = -(CW+2)'(dq) - (CW+2)'(dr);
		abs_q    = $unsigned(dq < 0 ? -dq : dq);
		abs_r    = $unsigned(dr < 0 ? -dr : dr);
		abs_s    = $unsigned(ds < 0 ? -ds : ds);
		sum      = (CW+3)'(abs_q) + (CW+3)'(abs_r) + (CW+3)'(abs_s);
		hex_dist = NW'(sum >> 1);
		far      = hex_dist > NW'(MAX_STEPS);
	end

	// A line out of range is handed on as a single-cell line at the start.
	always_comb begin
		push_plan.far = far;
		push_plan.n   = far ? '0 : STEP_BITS'(hex_dist);
		push_plan.dq  = far ? '0 : DLT_BITS'(dq);
		push_plan.dr  = far ? '0 : DLT_BITS'(dr);
		push_plan.ds  = far ? '0 : DLT_BITS'(ds);
	end

	assign push_org_q = line.start_q;
	assign push_org_r = line.start_r;
	assign push_valid = line.valid;
	assign line.ready = push_ready;

endmodule

`default_nettype wire

[sv/hld_queue.sv]
// ----------------------------------------------------------------------------
// hld_queue: plan queue
// Short first-in first-out buffer between the classifier and the stepper.
// ----------------------------------------------------------------------------
`default_nettype none

module hld_queue #(
	parameter int DATA_BITS = 8,
	parameter int DEPTH     = hld_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  logic [DATA_BITS-1:0] push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output logic [DATA_BITS-1:0] pop_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	logic [DATA_BITS-1:0] mem_q [DEPTH];
	logic [PW-1:0]        wr_ptr_q;
	logic [PW-1:0]        rd_ptr_q;
	logic [CNW-1:0]       cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = cnt_q < CNW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[sv/hld_back.sv]
// ----------------------------------------------------------------------------
// hld_back: line stepper
// Walks one line a cell per cycle unless the receiver stalls, keeping each
// coordinate's quotient and remainder over the distance, and drives the
// registered cell output.
`default_nettype none

module hld_back #(
	parameter int CW = hld_pkg::HLD_COORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  logic signed [CW-1:0] pop_org_q,
	input  logic signed [CW-1:0] pop_org_r,
	input  hld_pkg::step_plan_t  pop_plan,
	hld_cell_if.source           cells
);
	import hld_pkg::*;

	localparam int FW = CW + 2;

	logic                 active_q;
	logic                 out_valid_q;
	logic [STEP_BITS-1:0] idx_q;
	step_plan_t           plan_q;
	logic signed [CW-1:0] org_q_q;
	logic signed [CW-1:0] org_r_q;
	rnd_state_t           rq_q;
	rnd_state_t           rr_q;
	rnd_state_t           rs_q;   // tracks the negated s offset

	logic signed [CW-1:0] cq_q;
	logic signed [CW-1:0] cr_q;
	logic signed [CW:0]   cs_q;
	logic                 last_q;
	logic                 far_q;

	logic [STEP_BITS-1:0] den;
	logic [DLT_BITS-1:0]  den2;
	logic                 take;
	logic                 fire;
	logic                 is_last;
	logic signed [FW-1:0] base_q;
	logic signed [FW-1:0] base_r;
	logic signed [FW-1:0] qi;
	logic signed [FW-1:0] ri;
	logic signed [FW-1:0] si;
	logic signed [FW-1:0] qf;
	logic signed [FW-1:0] rf;
	logic signed [FW-1:0] sf;
	logic signed [ERR_BITS-1:0] eq;
	logic signed [ERR_BITS-1:0] er;
	logic signed [ERR_BITS-1:0] es;
	logic [KEY_BITS-1:0] kq;
	logic [KEY_BITS-1:0] kr;
	logic [KEY_BITS-1:0] ks;
	logic                fix_q;
	logic                fix_r;

	assign den     = (plan_q.n == '0) ? STEP_BITS'(1) : plan_q.n;
	assign den2    = {den, 1'b0};
	assign take    = pop_valid && !active_q;
	assign fire    = active_q && (!out_valid_q || cells.ready);
	assign is_last = idx_q == plan_q.n;
	assign pop_ready = !active_q;

	always_comb begin
		base_q = FW'(org_q_q);
		base_r = FW'(org_r_q);
		qi = base_q + FW'(rq_q.v);
		ri = base_r + FW'(rr_q.v);
		si = -base_q - base_r - FW'(rs_q.v);
		// Twice the rounding error of each component.
		eq = $signed({2'b00, den}) - $signed({1'b0, rq_q.rem});
		er = $signed({2'b00, den}) - $signed({1'b0, rr_q.rem});
		es = $signed({1'b0, rs_q.rem}) - $signed({2'b00, den});
		kq = key_up(eq);
		kr = key_up(er);
		ks = key_dn(es);
		fix_q = (kq > kr) && (kq > ks);
		fix_r = !fix_q && (kr > ks);
		qf = fix_q ? -ri - si : qi;
		rf = fix_r ? -qi - si : ri;
		sf = -qf - rf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (cells.ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				active_q <= 1'b1;
			end else if (fire && is_last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			plan_q  <= pop_plan;
			org_q_q <= pop_org_q;
			org_r_q <= pop_org_r;
			idx_q   <= '0;
			// At the start cell each remainder equals the distance.
			rq_q <= '{v: '0, rem: DLT_BITS'(pop_plan.n == '0 ? STEP_BITS'(1) : pop_plan.n)};
			rr_q <= '{v: '0, rem: DLT_BITS'(pop_plan.n == '0 ? STEP_BITS'(1) : pop_plan.n)};
			rs_q <= '{v: '0, rem: DLT_BITS'(pop_plan.n == '0 ? STEP_BITS'(1) : pop_plan.n)};
		end else if (fire && !is_last) begin
			idx_q <= idx_q + STEP_BITS'(1);
			rq_q  <= rnd_advance(rq_q, plan_q.dq, den2);
			rr_q  <= rnd_advance(rr_q, plan_q.dr, den2);
			rs_q  <= rnd_advance(rs_q, -plan_q.ds, den2);
		end
		if (fire) begin
			cq_q   <= CW'(qf);
			cr_q   <= CW'(rf);
			cs_q   <= (CW+1)'(sf);
			last_q <= is_last;
			far_q  <= plan_q.far;
		end
	end

	assign cells.valid     = out_valid_q;
	assign cells.cell_q    = cq_q;
	assign cells.cell_r    = cr_q;
	assign cells.cell_s    = cs_q;
	assign cells.last_cell = last_q;
	assign cells.too_far   = far_q;

endmodule

`default_nettype wire

[sv/hex_line_draw_core.sv]
// ----------------------------------------------------------------------------
// hex_line_draw_core: hex grid line drawing in cube coordinates
// Turns a start and end cell into the run of cells on the line between them.
// ----------------------------------------------------------------------------
// Usage:
// The line channel takes one beat per request: start_q, start_r, end_q and
// end_r, two's complement; the s coordinate is implied as -q-r. The cells
// channel then delivers N+1 beats, N being the hex distance, from the start
// cell to the end cell, with last_cell set on the final one. A request whose
// distance exceeds MAX_STEPS yields a single beat holding the start cell with
// last_cell and too_far both set.
// A request beat is written to the queue and, once the stepper is free,
// loaded into the stepper; each cell is then registered in the output
// register. A line occupies the stepper from its load until its last cell
// is registered, one cell per cycle unless the receiver stalls. Requests
// are classified on arrival and wait in a two-entry queue, so up to two
// further requests are taken while a line is being drawn.
// If the receiver stalls, the current cell holds in the output register and
// stepping pauses. Reset empties the queue and the output register; the
// block is then idle and ready for a request.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_line_draw_core #(
	parameter int COORD_BITS = hld_pkg::HLD_COORD_BITS,
	parameter int MAX_STEPS  = hld_pkg::HLD_MAX_STEPS
) (
	input  logic       clk,
	input  logic       arst_n,
	hld_line_if.sink   line,
	hld_cell_if.source cells
);
	import hld_pkg::*;

	localparam int QW = 2 * COORD_BITS + $bits(step_plan_t);

	// Classified request on its way into the queue.
	logic                         f_valid;
	logic                         f_ready;
	logic signed [COORD_BITS-1:0] f_org_q;
	logic signed [COORD_BITS-1:0] f_org_r;
	step_plan_t                   f_plan;

	// Head of the queue as seen by the stepper.
	logic                         q_valid;
	logic                         q_ready;
	logic [QW-1:0]                q_data;
	logic signed [COORD_BITS-1:0] b_org_q;
	logic signed [COORD_BITS-1:0] b_org_r;
	step_plan_t                   b_plan;

	hld_front #(
		.CW        (COORD_BITS),
		.MAX_STEPS (MAX_STEPS)
	) u_front (
		.line       (line),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_org_q (f_org_q),
		.push_org_r (f_org_r),
		.push_plan  (f_plan)
	);

	hld_queue #(
		.DATA_BITS (QW),
		.DEPTH     (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_org_q, f_org_r, f_plan}),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	assign {b_org_q, b_org_r, b_plan} = q_data;

	hld_back #(
		.CW (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_org_q (b_org_q),
		.pop_org_r (b_org_r),
		.pop_plan  (b_plan),
		.cells     (cells)
	);

	// Expected s of the cell on the output, for the consistency check below.
	logic signed [COORD_BITS:0] chk_s;
	assign chk_s = -(COORD_BITS+1)'(cells.cell_q) - (COORD_BITS+1)'(cells.cell_r);

`ifndef SYNTHESIS
	// An out-of-range result always closes its line.
	a_far_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		cells.valid |-> (!cells.too_far || cells.last_cell))
		else $error("too_far result without last_cell");

	// Every emitted cell lies on the cube plane q + r + s = 0.
	a_cube_plane: assert property (@(posedge clk) disable iff (!arst_n)
		cells.valid |-> (cells.cell_s == chk_s))
		else $error("cell_s does not match -q-r");

	// Once a plan leaves the queue the stepper is busy in the following cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |=> !q_ready)
		else $error("stepper took a plan while still drawing");

	// A request is refused only while the queue holds a waiting plan.
	a_refuse_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!line.ready |-> q_valid)
		else $error("request refused with an empty queue");
`endif

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for hex_line_draw_core
// Sends line requests on the line channel and checks every cell beat against
// cells predicted here from the exact fraction-over-N interpolation with the
// nudged cube rounding. A short table of hand-picked lines comes first, then
// random lines under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	import hld_pkg::*;

	localparam int CW          = HLD_COORD_BITS;
	localparam int STEP_LIMIT  = HLD_MAX_STEPS;
	localparam int CYCLE_LIMIT = 1000000;
	// Longest line plus load and output stages, with margin.
	localparam int SETTLE_CYCLES = 80;
	localparam int RANDOM_LINES  = 79;

	// One line request: start cell and end cell, q and r only.
	typedef struct packed {
		logic signed [CW-1:0] sq;
		logic signed [CW-1:0] sr;
		logic signed [CW-1:0] eq;
		logic signed [CW-1:0] er;
	} line_req_t;

	// One cell of a drawn line as the cells channel carries it.
	typedef struct packed {
		logic signed [CW-1:0] q;
		logic signed [CW-1:0] r;
		logic signed [CW:0]   s;
		logic                 last;
		logic                 far;
	} cell_t;

	// A row of the directed table. Where typed is set, the row yields one cell
	// that can be read off by eye, and that cell is the expectation.
	typedef struct packed {
		line_req_t rq;
		logic      typed;
		cell_t     want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	hld_line_if line_ch ();
	hld_cell_if cell_ch ();

	hex_line_draw_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.line   (line_ch),
		.cells  (cell_ch)
	);

	// Cells still owed by the block, oldest first.
	cell_t pending_cells[$];
	dir_row_t dir_table[$];

	int error_count = 0;
	int cycle_count = 0;
	// Percent chance per cycle that each side idles.
	int send_idle_pct = 12;
	int recv_idle_pct = 81;

	// Free-running clock, period 10.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	function automatic longint floor_div(input longint a, input longint b);
		longint quo;
		quo = a / b;
		if ((a % b) != 0 && a < 0)
			quo = quo - 1;
		return quo;
	endfunction

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Rounds num/den to the nearest integer. The q and r axes are nudged up by
	// an infinitely small amount, the s axis down by twice that, so ties go the
	// way the nudge points. The key orders the rounding errors so that equal
	// errors are again separated by the nudge.
	function automatic longint round_axis(input longint num, input longint den,
	                                      input bit toward_low, output longint key);
		longint v;
		longint d;
		if (!toward_low) begin
			v = floor_div(2 * num + den, 2 * den);
			d = v * den - num;
			key = (d > 0) ? (8 * d - 1) : (8 * (-d) + 1);
		end else begin
			v = -floor_div(-(2 * num - den), 2 * den);
			d = v * den - num;
			key = (d < 0) ? (8 * (-d) - 2) : (8 * d + 2);
		end
		return v;
	endfunction

	// Appends the cells of one line request to pending_cells.
	function automatic void plot_line(input line_req_t rq);
		longint q0, r0, s0, dq, dr, ds, n, den, i;
		longint qi, ri, si, kq, kr, ks;
		cell_t c;
		q0 = rq.sq;
		r0 = rq.sr;
		s0 = -q0 - r0;
		dq = longint'(rq.eq) - q0;
		dr = longint'(rq.er) - r0;
		ds = -dq - dr;
		n  = (mag(dq) + mag(dr) + mag(ds)) / 2;
		if (n > STEP_LIMIT) begin
			c.q    = rq.sq;
			c.r    = rq.sr;
			c.s    = (CW+1)'(-q0 - r0);
			c.last = 1'b1;
			c.far  = 1'b1;
			pending_cells = {pending_cells, c};
			return;
		end
		den = (n < 1) ? 1 : n;
		for (i = 0; i <= n; i++) begin
			qi = round_axis(q0 * den + dq * i, den, 1'b0, kq);
			ri = round_axis(r0 * den + dr * i, den, 1'b0, kr);
			si = round_axis(s0 * den + ds * i, den, 1'b1, ks);
			// The axis with the largest error is rebuilt from the other two.
			if (kq > kr && kq > ks)
				qi = -ri - si;
			else if (kr > ks)
				ri = -qi - si;
			c.q    = CW'(qi);
			c.r    = CW'(ri);
			c.s    = (CW+1)'(-qi - ri);
			c.last = (i == n);
			c.far  = 1'b0;
			pending_cells = {pending_cells, c};
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic dir_row_t mk_row(input int sq, input int sr, input int eq,
	                                    input int er, input bit typed, input int wq,
	                                    input int wr, input int ws, input bit wl,
	                                    input bit wf);
		dir_row_t row;
		row.rq.sq     = CW'(sq);
		row.rq.sr     = CW'(sr);
		row.rq.eq     = CW'(eq);
		row.rq.er     = CW'(er);
		row.typed     = typed;
		row.want.q    = CW'(wq);
		row.want.r    = CW'(wr);
		row.want.s    = (CW+1)'(ws);
		row.want.last = wl;
		row.want.far  = wf;
		return row;
	endfunction

	// Folds a coordinate plus offset back into range by taking the offset the
	// other way; the line then may come out longer, which is fine.
	function automatic int offset_coord(input int base, input int delta);
		int v;
		v = base + delta;
		if (v > 32767 || v < -32768)
			v = base - delta;
		return v;
	endfunction

	function automatic int random_coord();
		int v;
		if ($urandom_range(9) == 0) begin
			if ($urandom_range(1) == 1)
				v = 32767 - int'($urandom_range(70));
			else
				v = -32768 + int'($urandom_range(70));
		end else begin
			v = int'($urandom_range(65535)) - 32768;
		end
		return v;
	endfunction

	// Most lines are short, some reach up to the step limit, a few are bounded
	// by a limit from one below to one above it, and the rest have an arbitrary
	// end, which is nearly always too far.
	function automatic line_req_t random_line();
		line_req_t rq;
		int sq, sr, dq, dr, lim, lo, hi, sel;
		sel = int'($urandom_range(99));
		sq  = random_coord();
		sr  = random_coord();
		rq.sq = CW'(sq);
		rq.sr = CW'(sr);
		if (sel >= 92) begin
			rq.eq = CW'($urandom);
			rq.er = CW'($urandom);
			return rq;
		end
		if (sel < 60)
			lim = int'($urandom_range(8));
		else if (sel < 85)
			lim = int'($urandom_range(STEP_LIMIT));
		else
			lim = STEP_LIMIT - 1 + int'($urandom_range(2));
		dq = int'($urandom_range(2 * lim)) - lim;
		lo = (-lim > -lim - dq) ? -lim : -lim - dq;
		hi = (lim < lim - dq) ? lim : lim - dq;
		dr = lo + int'($urandom_range(hi - lo));
		rq.eq = CW'(offset_coord(sq, dq));
		rq.er = CW'(offset_coord(sr, dr));
		return rq;
	endfunction

	// Offers one request and returns at the edge where it is taken. Only one
	// value is scheduled per signal per edge, so a valid that stays high into
	// the next request is never dropped and raised in the same step.
	task automatic send_line(input line_req_t rq);
		while ($urandom_range(99) < send_idle_pct) begin
			line_ch.valid   <= 1'b0;
			line_ch.start_q <= CW'($urandom);
			line_ch.start_r <= CW'($urandom);
			line_ch.end_q   <= CW'($urandom);
			line_ch.end_r   <= CW'($urandom);
			@(posedge clk);
		end
		line_ch.valid   <= 1'b1;
		line_ch.start_q <= rq.sq;
		line_ch.start_r <= rq.sr;
		line_ch.end_q   <= rq.eq;
		line_ch.end_r   <= rq.er;
		do @(posedge clk); while (!line_ch.ready);
	endtask

	// Holds the sender off until every owed cell has come back.
	task automatic drain_cells();
		line_ch.valid <= 1'b0;
		while (pending_cells.size() != 0)
			@(posedge clk);
	endtask

	// A block of random lines with one full drain in the middle.
	task automatic run_random(input int count);
		line_req_t rq;
		for (int k = 0; k < count; k++) begin
			if (k == count / 2)
				drain_cells();
			rq = random_line();
			send_line(rq);
			plot_line(rq);
		end
		drain_cells();
	endtask

	task automatic compare_field(input string name, input longint want_v,
	                             input longint got_v, inout bit bad);
		if (want_v != got_v) begin
			bad = 1'b1;
			$display("%0t: %s mismatch, expected %0d, actual %0d",
			         $time, name, want_v, got_v);
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver: checks each accepted cell beat against the oldest owed cell,
	// then picks the next ready at random.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : cell_check
		cell_t want;
		bit bad;
		if (arst_n && cell_ch.valid && cell_ch.ready) begin
			if (pending_cells.size() == 0) begin
				error_count++;
				$display("%0t: unexpected cell beat, expected none, actual q=%0d r=%0d",
				         $time, cell_ch.cell_q, cell_ch.cell_r);
			end else begin
				want = pending_cells.pop_front();
				bad  = 1'b0;
				compare_field("cell_q", want.q, cell_ch.cell_q, bad);
				compare_field("cell_r", want.r, cell_ch.cell_r, bad);
				compare_field("cell_s", want.s, cell_ch.cell_s, bad);
				compare_field("last_cell", want.last, cell_ch.last_cell, bad);
				compare_field("too_far", want.far, cell_ch.too_far, bad);
				if (bad)
					error_count++;
			end
		end
		cell_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: a hang or a lost cell ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d cells still expected", $time, pending_cells.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		dir_row_t row;
		arst_n          = 1'b0;
		line_ch.valid   = 1'b0;
		line_ch.start_q = '0;
		line_ch.start_r = '0;
		line_ch.end_q   = '0;
		line_ch.end_r   = '0;

		// Equal cells, at the origin and at the corners of the range.
		dir_table = {dir_table, mk_row(0, 0, 0, 0, 1, 0, 0, 0, 1, 0)};
		dir_table = {dir_table, mk_row(32767, 32767, 32767, 32767, 1,
		                               32767, 32767, -65534, 1, 0)};
		// s of the most negative corner is +65536, which wraps in 17 bits.
		dir_table = {dir_table, mk_row(-32768, -32768, -32768, -32768, 1,
		                               -32768, -32768, -65536, 1, 0)};
		dir_table = {dir_table, mk_row(32767, -32768, 32767, -32768, 1,
		                               32767, -32768, 1, 1, 0)};
		// Lines that are too long return the start cell only.
		dir_table = {dir_table, mk_row(-32768, -32768, 32767, 32767, 1,
		                               -32768, -32768, -65536, 1, 1)};
		dir_table = {dir_table, mk_row(32767, -32768, -32768, 32767, 1,
		                               32767, -32768, 1, 1, 1)};
		dir_table = {dir_table, mk_row(0, 0, 64, 0, 1, 0, 0, 0, 1, 1)};
		dir_table = {dir_table, mk_row(5, -7, 5, 57, 1, 5, -7, 2, 1, 1)};
		// Exactly the step limit, along each kind of axis.
		dir_table = {dir_table, mk_row(0, 0, 63, 0, 0, 0, 0, 0, 0, 0)};
		dir_table = {dir_table, mk_row(0, 0, -63, 63, 0, 0, 0, 0, 0, 0)};
		dir_table = {dir_table, mk_row(100, -50, 100, 13, 0, 0, 0, 0, 0, 0)};
		// The six neighbors.
		dir_table = {dir_table, mk_row(0, 0, 1, 0, 0, 0, 0, 0, 0, 0)};
		dir_table = {dir_table, mk_row(0, 0, 1, -1, 0, 0, 0, 0, 0, 0)};
		dir_table = {dir_table, mk_row(0, 0, 0, -1, 0, 0, 0, 0, 0, 0)};
		dir_table = {dir_table, mk_row(0, 0, -1, 0, 0, 0, 0, 0, 0, 0)};
		dir_table = {dir_table, mk_row(0, 0, -1, 1, 0, 0, 0, 0, 0, 0)};
		dir_table = {dir_table, mk_row(0, 0, 0, 1, 0, 0, 0, 0, 0, 0)};
		// Midpoints that fall exactly between cells, so the nudge decides.
		dir_table = {dir_table, mk_row(0, 0, 2, -1, 0, 0, 0, 0, 0, 0)};
		dir_table = {dir_table, mk_row(0, 0, 1, 1, 0, 0, 0, 0, 0, 0)};
		dir_table = {dir_table, mk_row(0, 0, -1, -1, 0, 0, 0, 0, 0, 0)};
		dir_table = {dir_table, mk_row(0, 0, 1, -2, 0, 0, 0, 0, 0, 0)};
		// Lines hugging the edges of the coordinate range, two of them full-length.
		dir_table = {dir_table, mk_row(32767, -32768, 32704, -32705, 0, 0, 0, 0, 0, 0)};
		dir_table = {dir_table, mk_row(-32768, 32767, -32705, 32704, 0, 0, 0, 0, 0, 0)};
		dir_table = {dir_table, mk_row(-32768, 0, -32765, -10, 0, 0, 0, 0, 0, 0)};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: sender mostly busy, receiver mostly stalled.
		send_idle_pct = 12;
		recv_idle_pct = 81;
		foreach (dir_table[k]) begin
			row = dir_table[k];
			send_line(row.rq);
			if (row.typed)
				pending_cells = {pending_cells, row.want};
			else
				plot_line(row.rq);
		end
		drain_cells();
		run_random(RANDOM_LINES);

		// Phase two: the other way round.
		send_idle_pct = 81;
		recv_idle_pct = 12;
		run_random(RANDOM_LINES);

		// Phase three: both sides at full rate.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(RANDOM_LINES);

		// Give any stray beat time to show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

[hex_line_draw_core.f]
sv/hld_pkg.sv
sv/hld_line_if.sv
sv/hld_cell_if.sv
sv/hld_front.sv
sv/hld_queue.sv
sv/hld_back.sv
sv/hex_line_draw_core.sv
test/tb.sv
